### hw/rtl/andf_pkg.sv
// Shared types and constants for the Annex B NAL deframer.
// Used by the front, queue, back and top-level modules.
package andf_pkg;

   localparam int MaxResults = 5;
   localparam int CountWidth = 3;
   localparam int PushSlots  = 4;

   localparam logic [7:0] ByteZero      = 8'h00;
   localparam logic [7:0] ByteOne       = 8'h01;
   localparam logic [1:0] ZeroRunMax    = 2'd3;
   localparam logic [1:0] ZeroRunStart  = 2'd2;
   localparam logic [1:0] UnitLengthMax = 2'd2;

   typedef struct packed {
      logic [7:0] nal_byte;
      logic       has_byte;
      logic       first_of_nal;
      logic       last_of_nal;
      logic       too_short;
      logic       empty_nal;
      logic       at_buffer_end;
   } result_type;

   typedef struct packed {
      result_type [MaxResults-1:0] results;
      logic [CountWidth-1:0]       count;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hw/rtl/andf_front.sv
// Front end: accepts stream bytes, tracks start-code state and builds the
// list of results each byte causes. Depends on andf_pkg.
module andf_front import andf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_buffer,
   input  queue_status_type q_status,
   output logic             q_push,
   output entry_type        q_entry
);

   logic [1:0] zero_run_ff, zero_run_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       inside_unit_ff, inside_unit_in;
   logic [1:0] unit_length_ff, unit_length_in;
   logic       first_pending_ff, first_pending_in;

   result_type [MaxResults-1:0] res_list;
   logic [CountWidth-1:0]       res_count;
   logic [CountWidth-1:0]       push_zeros;
   logic [CountWidth-1:0]       push_total;
   logic                        push_b;
   logic                        is_start;
   logic                        close_req;
   logic                        close_atend;
   logic [7:0]                  push_value;
   logic                        accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      zero_run_in      = zero_run_ff;
      held_byte_in     = held_byte_ff;
      held_valid_in    = held_valid_ff;
      inside_unit_in   = inside_unit_ff;
      unit_length_in   = unit_length_ff;
      first_pending_in = first_pending_ff;
      res_list         = '0;
      res_count        = '0;
      push_zeros       = '0;
      push_b           = 1'b0;
      close_req        = 1'b0;
      close_atend      = 1'b0;
      push_value       = ByteZero;
      is_start         = (req_data_byte == ByteOne) && (zero_run_ff >= ZeroRunStart);

      if (is_start) begin
         close_req = inside_unit_ff;
      end else begin
         if (req_data_byte == ByteZero) begin
            if (zero_run_ff < ZeroRunMax) begin
               zero_run_in = zero_run_ff + 2'd1;
            end else if (inside_unit_ff) begin
               push_zeros = 3'd1;
            end
         end else begin
            if (inside_unit_ff) begin
               push_zeros = {1'b0, zero_run_ff};
               push_b     = 1'b1;
            end
            zero_run_in = '0;
         end
         if (req_end_of_buffer && inside_unit_ff) begin
            push_zeros = push_zeros + {1'b0, zero_run_in};
         end
      end
      push_total = push_zeros + {2'b00, push_b};

      // emit the held byte on each push, then hold the new one
      for (int i = 0; i < PushSlots; i++) begin
         if (CountWidth'(i) < push_total) begin
            push_value = (push_b && (CountWidth'(i) == push_total - 3'd1)) ?
                         req_data_byte : ByteZero;
            if (held_valid_in) begin
               res_list[res_count] = '{nal_byte: held_byte_in, has_byte: 1'b1,
                                       first_of_nal: first_pending_in,
                                       last_of_nal: 1'b0, too_short: 1'b0,
                                       empty_nal: 1'b0, at_buffer_end: 1'b0};
               res_count        = res_count + 3'd1;
               first_pending_in = 1'b0;
            end
            held_byte_in  = push_value;
            held_valid_in = 1'b1;
            if (unit_length_in < UnitLengthMax) begin
               unit_length_in = unit_length_in + 2'd1;
            end
         end
      end

      if (!is_start && req_end_of_buffer && inside_unit_ff && held_valid_in) begin
         close_req   = 1'b1;
         close_atend = 1'b1;
      end

      if (close_req) begin
         if (held_valid_in) begin
            res_list[res_count] = '{nal_byte: held_byte_in, has_byte: 1'b1,
                                    first_of_nal: first_pending_in,
                                    last_of_nal: 1'b1,
                                    too_short: (unit_length_in < UnitLengthMax),
                                    empty_nal: 1'b0, at_buffer_end: close_atend};
         end else begin
            res_list[res_count] = '{nal_byte: ByteZero, has_byte: 1'b0,
                                    first_of_nal: 1'b0, last_of_nal: 1'b0,
                                    too_short: 1'b0, empty_nal: 1'b1,
                                    at_buffer_end: close_atend};
         end
         res_count        = res_count + 3'd1;
         held_valid_in    = 1'b0;
         first_pending_in = 1'b0;
      end

      if (is_start) begin
         inside_unit_in   = 1'b1;
         first_pending_in = 1'b1;
         unit_length_in   = '0;
         held_valid_in    = 1'b0;
         zero_run_in      = '0;
      end

      if (req_end_of_buffer) begin
         zero_run_in      = '0;
         held_byte_in     = ByteZero;
         held_valid_in    = 1'b0;
         inside_unit_in   = 1'b0;
         unit_length_in   = '0;
         first_pending_in = 1'b0;
      end
   end

   assign q_push        = accept && (res_count != '0);
   assign q_entry.results = res_list;
   assign q_entry.count   = res_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff      <= '0;
         held_byte_ff     <= ByteZero;
         held_valid_ff    <= 1'b0;
         inside_unit_ff   <= 1'b0;
         unit_length_ff   <= '0;
         first_pending_ff <= 1'b0;
      end else if (accept) begin
         zero_run_ff      <= zero_run_in;
         held_byte_ff     <= held_byte_in;
         held_valid_ff    <= held_valid_in;
         inside_unit_ff   <= inside_unit_in;
         unit_length_ff   <= unit_length_in;
         first_pending_ff <= first_pending_in;
      end
   end

endmodule

### hw/rtl/andf_queue.sv
// Short FIFO of result lists between front and back end.
// Depends on andf_pkg for the entry type.
module andf_queue import andf_pkg::*; #(
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);

   entry_type [Depth-1:0]  mem_ff;
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]    count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == CntWidth'(Depth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/andf_back.sv
// Back end: walks the result list at the queue head, one result per cycle
// while rsp_stall does not hold it, into the output register. Depends on andf_pkg.
module andf_back import andf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output result_type       rsp_result,
   output logic             rsp_run_end
);

   logic [CountWidth-1:0] index_ff, index_in;
   logic                  rsp_valid_ff;
   result_type            rsp_result_ff;
   logic                  rsp_run_end_ff;
   logic                  load;
   logic                  last;

   assign load  = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign last  = (index_ff == head.count - CountWidth'(1));
   assign q_pop = load && last;

   always_comb begin
      index_in = index_ff;
      if (load) begin
         index_in = last ? '0 : index_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= !q_status.empty;
         end
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_result_ff  <= head.results[index_ff];
         rsp_run_end_ff <= last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_result  = rsp_result_ff;
   assign rsp_run_end = rsp_run_end_ff;

endmodule

### hw/rtl/annexb_nal_deframer.sv
// Annex B NAL unit deframer, top level.
// Connects front end, result queue and back end; depends on andf_pkg.
//
// Usage:
//   Input channel req_*: one stream byte per transaction, with
//   req_end_of_buffer marking the last byte of a buffer.
//   Result channel rsp_*: one result per transaction; rsp_run_end marks
//   the last result caused by one input byte. Bytes that cause no result
//   produce no transaction.
//   A byte's results are registered in the queue, then in the output
//   register. Throughput: one byte per cycle while each byte causes at
//   most one result and rsp_stall is low; the back end emits one result
//   per cycle while not stalled, so a byte with k results occupies it
//   until all k are out; the queue (QueueDepth result lists) absorbs
//   bursts. Bytes are accepted one per cycle until the queue is full.
//   Reset: synchronous; clears start-code state, the queue pointers and
//   the output valid flag. No configuration.
//   Receiver stall: rsp_stall holds the output register; the queue keeps
//   filling and req_stall rises once it is full.
module annexb_nal_deframer import andf_pkg::*; #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_nal_byte,
   output logic       rsp_has_byte,
   output logic       rsp_first_of_nal,
   output logic       rsp_last_of_nal,
   output logic       rsp_too_short,
   output logic       rsp_empty_nal,
   output logic       rsp_at_buffer_end,
   output logic       rsp_run_end
);

   queue_status_type q_status;
   entry_type        q_entry;
   entry_type        q_head;
   logic             q_push;
   logic             q_pop;
   result_type       rsp_result;

   andf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_entry           (q_entry)
   );

   andf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   andf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result),
      .rsp_run_end (rsp_run_end)
   );

   assign rsp_nal_byte      = rsp_result.nal_byte;
   assign rsp_has_byte      = rsp_result.has_byte;
   assign rsp_first_of_nal  = rsp_result.first_of_nal;
   assign rsp_last_of_nal   = rsp_result.last_of_nal;
   assign rsp_too_short     = rsp_result.too_short;
   assign rsp_empty_nal     = rsp_result.empty_nal;
   assign rsp_at_buffer_end = rsp_result.at_buffer_end;

endmodule

### hw/rtl/andf_checker.sv
// Port-level checks for the Annex B NAL deframer, bound to the top level.
// Sees only the ports of annexb_nal_deframer.
module andf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_end_of_buffer,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_nal_byte,
   input logic       rsp_has_byte,
   input logic       rsp_first_of_nal,
   input logic       rsp_last_of_nal,
   input logic       rsp_too_short,
   input logic       rsp_empty_nal,
   input logic       rsp_at_buffer_end,
   input logic       rsp_run_end
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_nal_byte)
         && $stable(rsp_run_end) && $stable(rsp_last_of_nal))
      else $error("result changed while stalled");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_nal_byte == 8'h00 && rsp_empty_nal)
      else $error("result without payload is not an empty unit");

   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_nal |-> !rsp_has_byte && !rsp_first_of_nal
         && !rsp_last_of_nal && !rsp_too_short)
      else $error("empty unit carries byte flags");

   a_close_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_last_of_nal || rsp_empty_nal) |-> rsp_run_end)
      else $error("unit close is not the last result of its byte");

   a_short_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_too_short || rsp_at_buffer_end) |->
         rsp_last_of_nal || rsp_empty_nal)
      else $error("close flag outside a closing result");

endmodule

bind annexb_nal_deframer andf_checker u_checker (.*);
